>>> hdl/pihdr_pkg.sv
// shared types and constants for the pulse header injector
package pihdr_pkg;

    localparam int          HEADER_LEN  = 8;
    localparam int          HDR_IDX_W   = $clog2(HEADER_LEN);
    localparam logic [31:0] HEADER_MARK = 32'hba5eba11;
    localparam logic [31:0] PAD_WORD    = 32'h75757575;

    // input beat layout, msb first
    typedef struct packed {
        logic [2:0]  fill;
        logic [31:0] meta_period;
        logic [31:0] meta_samples;
        logic [31:0] meta_sequence;
        logic [3:0]  meta_position;
        logic        meta_terminate;
        logic [15:0] status_flags;
        logic [31:0] encoder_b;
        logic [31:0] encoder_a;
        logic [31:0] sample_data;
    } in_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_HDR,
        ST_DATA
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PASS,
        OP_TERM,
        OP_CAPTURE,
        OP_PAD,
        OP_HDR,
        OP_DATA
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic in_sync;
        logic in_term;
        logic pads_zero;
        logic pad_last;
        logic hdr_last;
        logic out_free;
    } stat_t;

endpackage

>>> hdl/pihdr_ctrl.sv
// sequencer for pass, pad, header and sample beats
module pihdr_ctrl
    import pihdr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = stat.out_free;
                if (s_tvalid && stat.out_free) begin
                    if (!stat.in_sync) begin
                        cmd.op = OP_PASS;
                    end else if (stat.in_term) begin
                        cmd.op = OP_TERM;
                    end else begin
                        cmd.op     = OP_CAPTURE;
                        state_next = stat.pads_zero ? ST_HDR : ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (stat.out_free) begin
                    cmd.op = OP_PAD;
                    if (stat.pad_last) state_next = ST_HDR;
                end
            end
            ST_HDR: begin
                if (stat.out_free) begin
                    cmd.op = OP_HDR;
                    if (stat.hdr_last) state_next = ST_DATA;
                end
            end
            ST_DATA: begin
                if (stat.out_free) begin
                    cmd.op     = OP_DATA;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/pihdr_dp.sv
// pulse state, captured header fields and output register
module pihdr_dp
    import pihdr_pkg::*;
#(
    parameter int PAD_LIMIT = 55
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [215:0] s_tdata,
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    input  cmd_t         cmd,
    output stat_t        stat
);

    // pad counter wide enough for the pad limit
    localparam int PAD_CNT_W = (PAD_LIMIT > 0) ? $clog2(PAD_LIMIT + 1) : 1;

    in_beat_t in_beat;
    assign in_beat = in_beat_t'(s_tdata);

    logic        pulse_active_reg, pulse_active_next;
    logic        bundle_active_reg, bundle_active_next;
    logic        end_bundle_reg;
    logic [31:0] expected_reg;
    logic [31:0] seen_reg;

    logic [15:0]          status_reg;
    logic [3:0]           position_reg;
    logic [31:0]          enc_a_reg, enc_b_reg, sequence_reg, period_reg, data_reg;
    logic                 trunc_reg;
    logic [PAD_CNT_W-1:0] pad_cnt_reg;
    logic [HDR_IDX_W-1:0] hdr_idx_reg;

    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_gate_reg, out_sync_reg, out_trunc_reg, out_last_reg;

    logic [31:0]          missing;
    logic                 over_limit;
    logic [PAD_CNT_W-1:0] pads;
    logic [31:0]          hdr_word;
    logic                 pass_end;
    logic                 out_free;

    always_comb begin
        missing    = (seen_reg < expected_reg) ? (expected_reg - seen_reg) : 32'd0;
        over_limit = missing > 32'(PAD_LIMIT);
        pads       = over_limit ? PAD_CNT_W'(PAD_LIMIT) : missing[PAD_CNT_W-1:0];
    end

    assign pass_end           = (seen_reg == expected_reg);
    assign pulse_active_next  = pass_end ? 1'b0 : pulse_active_reg;
    assign bundle_active_next = (pass_end && end_bundle_reg) ? 1'b0 : bundle_active_reg;
    assign out_free           = !out_valid_reg || m_tready;

    always_comb begin
        case (hdr_idx_reg)
            3'd0:    hdr_word = HEADER_MARK;
            3'd1:    hdr_word = {12'd0, position_reg, status_reg};
            3'd2:    hdr_word = enc_a_reg;
            3'd3:    hdr_word = enc_b_reg;
            3'd4:    hdr_word = sequence_reg;
            3'd5:    hdr_word = expected_reg;
            3'd6:    hdr_word = period_reg;
            default: hdr_word = 32'd0;
        endcase
    end

    always_comb begin
        stat.in_sync   = s_tuser[0];
        stat.in_term   = in_beat.meta_terminate;
        stat.pads_zero = (pads == '0);
        stat.pad_last  = (pad_cnt_reg == PAD_CNT_W'(1));
        stat.hdr_last  = (hdr_idx_reg == HDR_IDX_W'(HEADER_LEN - 1));
        stat.out_free  = out_free;
    end

    // pulse and bundle state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_active_reg  <= 1'b0;
            bundle_active_reg <= 1'b0;
            end_bundle_reg    <= 1'b0;
            expected_reg      <= 32'd0;
            seen_reg          <= 32'd0;
        end else begin
            unique case (cmd.op)
                OP_PASS: begin
                    pulse_active_reg  <= pulse_active_next;
                    bundle_active_reg <= bundle_active_next;
                    seen_reg          <= seen_reg + 32'd1;
                end
                OP_TERM: begin
                    pulse_active_reg  <= 1'b0;
                    bundle_active_reg <= 1'b0;
                    end_bundle_reg    <= 1'b0;
                    expected_reg      <= 32'd0;
                    seen_reg          <= 32'd0;
                end
                OP_CAPTURE: begin
                    pulse_active_reg  <= 1'b1;
                    bundle_active_reg <= 1'b1;
                    end_bundle_reg    <= in_beat.meta_position[3];
                    expected_reg      <= in_beat.meta_samples;
                    seen_reg          <= 32'd1;
                end
                default: begin
                end
            endcase
        end
    end

    // captured sync beat and run counters
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_CAPTURE: begin
                status_reg   <= in_beat.status_flags;
                position_reg <= in_beat.meta_position;
                enc_a_reg    <= in_beat.encoder_a;
                enc_b_reg    <= in_beat.encoder_b;
                sequence_reg <= in_beat.meta_sequence;
                period_reg   <= in_beat.meta_period;
                data_reg     <= in_beat.sample_data;
                trunc_reg    <= over_limit;
                pad_cnt_reg  <= pads;
                hdr_idx_reg  <= '0;
            end
            OP_PAD:  pad_cnt_reg <= pad_cnt_reg - PAD_CNT_W'(1);
            OP_HDR:  hdr_idx_reg <= hdr_idx_reg + HDR_IDX_W'(1);
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            case (cmd.op)
                OP_PASS:                out_valid_reg <= pulse_active_next || !bundle_active_next;
                OP_PAD, OP_HDR, OP_DATA: out_valid_reg <= 1'b1;
                default:                if (m_tready) out_valid_reg <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_PASS: begin
                out_data_reg  <= in_beat.sample_data;
                out_gate_reg  <= pulse_active_next;
                out_sync_reg  <= 1'b0;
                out_trunc_reg <= 1'b0;
                out_last_reg  <= 1'b1;
            end
            OP_PAD: begin
                out_data_reg  <= PAD_WORD;
                out_gate_reg  <= 1'b1;
                out_sync_reg  <= 1'b0;
                out_trunc_reg <= trunc_reg;
                out_last_reg  <= 1'b0;
            end
            OP_HDR: begin
                out_data_reg  <= hdr_word;
                out_gate_reg  <= 1'b1;
                out_sync_reg  <= 1'b1;
                out_trunc_reg <= trunc_reg;
                out_last_reg  <= 1'b0;
            end
            OP_DATA: begin
                out_data_reg  <= data_reg;
                out_gate_reg  <= 1'b1;
                out_sync_reg  <= 1'b0;
                out_trunc_reg <= trunc_reg;
                out_last_reg  <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_trunc_reg, out_sync_reg, out_gate_reg};
    assign m_tlast  = out_last_reg;

endmodule

>>> hdl/pulse_header_injector_core.sv
// top level of the pulse header injector
// A non-sync sample beat is taken and leaves through the output register,
// so the sample stream runs at one beat per clock while the consumer keeps
// m_tready high. Words between pulses inside a transfer bundle are dropped
// and give no output beat. A sync beat with terminate set clears the pulse
// state and gives no output. Any other sync beat is taken and then holds
// the input while the sequencer emits the pad words (at most PAD_LIMIT),
// the eight header words and the sample word itself, one per cycle through
// the single output register; a stalled consumer adds its stall cycles.
// m_tlast marks the final beat caused by one input beat.
module pulse_header_injector_core
    import pihdr_pkg::*;
#(
    parameter int PAD_LIMIT = 55
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input beats
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] sample_data, [63:32] encoder_a, [95:64] encoder_b,
    // [111:96] status_flags, [112] meta_terminate, [116:113] meta_position,
    // [148:117] meta_sequence, [180:149] meta_samples, [212:181] meta_period,
    // [215:213] zero
    input  logic [215:0] s_tdata,
    // [0] sync_in
    input  logic [0:0]   s_tuser,
    // output beats
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] out_data
    output logic [31:0]  m_tdata,
    // [0] out_gate, [1] out_sync, [2] pad_truncated
    output logic [2:0]   m_tuser,
    // last_of_run
    output logic         m_tlast
);

    // controller to datapath commands and status back
    cmd_t  cmd;
    stat_t stat;

    pihdr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pihdr_dp #(
        .PAD_LIMIT (PAD_LIMIT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

    // input is taken only when the output register can take a beat
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (m_tready || !m_tvalid))
        else $error("input ready while output register is blocked");

    // header beats are always inside a pulse and never end a run
    a_sync_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tuser[0] && !m_tlast))
        else $error("header beat without gate or with last");

    // truncation only ever marks beats of a sync run
    a_trunc_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |-> m_tuser[0])
        else $error("truncation flag on an ungated beat");

    // a capture holds off the input for at least the next cycle
    a_capture_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_CAPTURE) |=> !s_tready)
        else $error("input ready right after a sync capture");

endmodule
